FILE: src/ds_twr_distance_fir_smoother_defines.svh
// Assertion macros shared by the verification files of the ranging smoother.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef DS_TWR_DISTANCE_FIR_SMOOTHER_DEFINES_SVH
`define DS_TWR_DISTANCE_FIR_SMOOTHER_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define DSTWR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ranging smoother assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define DSTWR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ranging smoother assertion failed");

`endif

FILE: src/dstwr_pkg.sv
// Package for the ranging smoother: widths, FIR coefficients, FSM states and
// the controller-to-datapath command struct. No dependencies.
package dstwr_pkg;

	localparam int TAPS       = 31;
	localparam int STAMP_BITS = 40;
	localparam int NCOEF      = 31;
	localparam int CM_W       = 32;
	localparam int QUO_W      = 32;
	localparam int PROD_W     = 2 * STAMP_BITS;
	localparam int NUM_W      = PROD_W + CM_W;
	localparam int DEN_W      = STAMP_BITS + 2;
	localparam int DIVD_W     = DEN_W + 24;
	localparam int CNT_W      = 7;
	localparam int TAP_IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int COEF_W     = 17;
	localparam int MPROD_W    = 32 + COEF_W;
	localparam int ACC_W      = 58;
	localparam logic [CM_W-1:0] CM_RESET = 32'd2014493000;

	localparam logic signed [COEF_W-1:0] COEF_Q16 [NCOEF] = '{
		17'sd109, 17'sd126, 17'sd123, 17'sd47, -17'sd161, -17'sd510, -17'sd913,
		-17'sd1170, -17'sd1012, -17'sd190, 17'sd1412, 17'sd3694, 17'sd6318,
		17'sd8779, 17'sd10532, 17'sd11169, 17'sd10532, 17'sd8779, 17'sd6318,
		17'sd3694, 17'sd1412, -17'sd190, -17'sd1012, -17'sd1170, -17'sd913,
		-17'sd510, -17'sd161, 17'sd47, 17'sd123, 17'sd126, 17'sd109
	};

	// Taps past the table have a zero coefficient.
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		c = '0;
		for (int i = 0; i < NCOEF; i++) begin
			if (int'(idx) == i) begin
				c = COEF_Q16[i];
			end
		end
		return c;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_MAG, ST_SCALE, ST_CHECK, ST_DIV, ST_PUSH, ST_FIR,
		ST_TAIL, ST_DONE
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 mul_step;
		logic                 mag;
		logic                 scale_step;
		logic                 check;
		logic                 div_step;
		logic                 push;
		logic                 mac;
		logic                 finish;
		logic [TAP_IDX_W-1:0] tap;
	} dp_cmd_t;

endpackage

FILE: src/dstwr_ctrl.sv
// Sequencing controller of the ranging smoother. Depends on dstwr_pkg.
// Steps the datapath through multiply, scale, divide and filter phases.
module dstwr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output dstwr_pkg::dp_cmd_t cmd
);
	import dstwr_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.tap = cnt_q[TAP_IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNT_W'(STAMP_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ST_MAG;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_step = 1'b1;
				if (cnt_q == CNT_W'(CM_W - 1)) begin
					cnt_d   = '0;
					state_d = ST_CHECK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					cnt_d   = '0;
					state_d = ST_PUSH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_FIR;
			end
			ST_FIR: begin
				cmd.mac = 1'b1;
				if (cnt_q == CNT_W'(TAPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_TAIL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_TAIL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: src/dstwr_dp.sv
// Datapath of the ranging smoother: shift-add multipliers, restoring divider,
// delay line and serial FIR accumulator. Depends on dstwr_pkg.
module dstwr_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dstwr_pkg::dp_cmd_t               cmd,
	input  logic [dstwr_pkg::CM_W-1:0]       cm_per_tick_q32,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] poll_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] poll_rx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] resp_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] resp_rx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] final_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] final_rx_time,
	output logic signed [31:0]               smoothed_distance_q8,
	output logic                             zero_denominator
);
	import dstwr_pkg::*;

	localparam int PAD_W = PROD_W - DIVD_W;

	logic [STAMP_BITS-1:0] ra_q, rb_q, da_q, db_q;
	logic [PROD_W-1:0]     p1_q, p2_q;
	logic                  neg_q;
	logic [NUM_W-1:0]      num_q;
	logic [CM_W-1:0]       cm_sh_q;
	logic [DEN_W-1:0]      den_q;
	logic                  zden_q, ovf_q;
	logic [DIVD_W-1:0]     rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic signed [31:0]    hist_q [TAPS];
	logic signed [MPROD_W-1:0] prod_s1;
	logic                  mac_v_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]    dist_q;
	logic                  zero_q;

	logic [STAMP_BITS-1:0] ra_w, rb_w, da_w, db_w;
	logic [DIVD_W-1:0]     den_sh;
	logic [DIVD_W:0]       trial;
	logic [QUO_W-1:0]      lim, qsat;
	logic signed [31:0]    raw;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-17:0] yv;
	logic signed [31:0]    ysat;

	assign ra_w   = resp_rx_time - poll_tx_time;
	assign db_w   = resp_tx_time - poll_rx_time;
	assign rb_w   = final_rx_time - resp_tx_time;
	assign da_w   = final_tx_time - resp_rx_time;
	assign den_sh = {den_q, 24'd0};
	assign trial  = {rem_q, num_q[QUO_W-1]};

	always_comb begin
		lim  = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		qsat = (ovf_q || (quo_q > lim)) ? lim : quo_q;
		if (zden_q) begin
			raw = '0;
		end else if (neg_q) begin
			raw = -$signed(qsat);
		end else begin
			raw = $signed(qsat);
		end
	end

	// Round to nearest with ties upward, then saturate to 32 bits.
	always_comb begin
		rnd = acc_q + ACC_W'(32768);
		yv  = rnd[ACC_W-1:16];
		if (yv > $signed((ACC_W-16)'(32'sh7FFF_FFFF))) begin
			ysat = 32'sh7FFF_FFFF;
		end else if (yv < -$signed((ACC_W-16)'(33'sh0_8000_0000))) begin
			ysat = 32'sh8000_0000;
		end else begin
			ysat = yv[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q    <= ra_w;
			rb_q    <= rb_w;
			da_q    <= da_w;
			db_q    <= db_w;
			den_q   <= DEN_W'(ra_w) + DEN_W'(rb_w) + DEN_W'(da_w) + DEN_W'(db_w);
			p1_q    <= '0;
			p2_q    <= '0;
			cm_sh_q <= cm_per_tick_q32;
		end
		if (cmd.mul_step) begin
			p1_q <= {p1_q[PROD_W-2:0], 1'b0}
				+ (rb_q[STAMP_BITS-1] ? PROD_W'(ra_q) : '0);
			p2_q <= {p2_q[PROD_W-2:0], 1'b0}
				+ (db_q[STAMP_BITS-1] ? PROD_W'(da_q) : '0);
			rb_q <= {rb_q[STAMP_BITS-2:0], 1'b0};
			db_q <= {db_q[STAMP_BITS-2:0], 1'b0};
		end
		if (cmd.mag) begin
			neg_q <= (p1_q < p2_q);
			p1_q  <= (p1_q < p2_q) ? (p2_q - p1_q) : (p1_q - p2_q);
			num_q <= '0;
		end
		if (cmd.scale_step) begin
			num_q   <= {num_q[NUM_W-2:0], 1'b0}
				+ (cm_sh_q[CM_W-1] ? NUM_W'(p1_q) : '0);
			cm_sh_q <= {cm_sh_q[CM_W-2:0], 1'b0};
		end
		if (cmd.check) begin
			ovf_q  <= (num_q[NUM_W-1:QUO_W] >= {{PAD_W{1'b0}}, den_sh});
			rem_q  <= num_q[QUO_W+DIVD_W-1:QUO_W];
			zden_q <= (den_q == '0);
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			if (trial >= {1'b0, den_sh}) begin
				rem_q <= DIVD_W'(trial - {1'b0, den_sh});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVD_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end
		if (cmd.mac) begin
			prod_s1 <= hist_q[0] * coef_at(cmd.tap);
		end
		if (cmd.push) begin
			acc_q <= '0;
		end else if (mac_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.finish) begin
			dist_q <= ysat;
			zero_q <= zden_q;
		end
	end

	// The delay line shifts on a new sample and rotates once per tap while
	// filtering, so the filter always reads its head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
			end
			mac_v_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac;
			if (cmd.push) begin
				for (int i = TAPS - 1; i > 0; i--) begin
					hist_q[i] <= hist_q[i-1];
				end
				hist_q[0] <= raw;
			end else if (cmd.mac) begin
				for (int i = 0; i < TAPS - 1; i++) begin
					hist_q[i] <= hist_q[i+1];
				end
				hist_q[TAPS-1] <= hist_q[0];
			end
		end
	end

	assign smoothed_distance_q8 = dist_q;
	assign zero_denominator     = zero_q;

endmodule

FILE: src/ds_twr_distance_fir_smoother.sv
// Top level of the double-sided two-way ranging distance smoother.
// Depends on dstwr_pkg, dstwr_ctrl and dstwr_dp.
//
// Each input item is one ranging exchange of six 40-bit radio timestamps.
// The block forms the four round and reply intervals modulo 2^40, computes
// the asymmetric time of flight (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db) exactly,
// scales it to Q8 centimetres with the cm_per_tick_q32 register, pushes the
// result into a 31-deep delay line and emits the 31-tap FIR output, rounded
// and saturated. A zero interval sum gives a raw distance of zero and sets
// zero_denominator on that result. One item is processed at a time.
// Between acceptance and the result being presented, the two interval
// products run on two shift-add units side by side, then come the scaling
// multiply, the restoring divider and the serial multiply-accumulate over
// the delay line, with setup and wrap-up steps around them. A finished
// result waits in the output register while the next item is already
// being accepted. The delay line is cleared by reset. The configuration
// register is always ready and should only be written while no item is in
// flight.
module ds_twr_distance_fir_smoother (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dstwr_pkg::CM_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] poll_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] poll_rx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] resp_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] resp_rx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] final_tx_time,
	input  logic [dstwr_pkg::STAMP_BITS-1:0] final_rx_time,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               smoothed_distance_q8,
	output logic                             zero_denominator
);
	import dstwr_pkg::*;

	dp_cmd_t         cmd;
	logic [CM_W-1:0] cm_q;

	// Scale register; it is sampled into the datapath when an item starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q <= CM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cm_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	dstwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dstwr_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.cm_per_tick_q32      (cm_q),
		.poll_tx_time         (poll_tx_time),
		.poll_rx_time         (poll_rx_time),
		.resp_tx_time         (resp_tx_time),
		.resp_rx_time         (resp_rx_time),
		.final_tx_time        (final_tx_time),
		.final_rx_time        (final_rx_time),
		.smoothed_distance_q8 (smoothed_distance_q8),
		.zero_denominator     (zero_denominator)
	);

endmodule

FILE: src/dstwr_checker.sv
// Port-level assertions for the ranging smoother, bound to its top level.
// Depends on dstwr_pkg and ds_twr_distance_fir_smoother_defines.svh.
`include "ds_twr_distance_fir_smoother_defines.svh"

module dstwr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [dstwr_pkg::CM_W-1:0]       cfg_data,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [dstwr_pkg::STAMP_BITS-1:0] poll_tx_time,
	input logic [dstwr_pkg::STAMP_BITS-1:0] poll_rx_time,
	input logic [dstwr_pkg::STAMP_BITS-1:0] resp_tx_time,
	input logic [dstwr_pkg::STAMP_BITS-1:0] resp_rx_time,
	input logic [dstwr_pkg::STAMP_BITS-1:0] final_tx_time,
	input logic [dstwr_pkg::STAMP_BITS-1:0] final_rx_time,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [31:0]               smoothed_distance_q8,
	input logic                             zero_denominator
);

	// A stalled result holds its value.
	`DSTWR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(smoothed_distance_q8) && $stable(zero_denominator))

	// An accepted item keeps the block busy for its whole computation.
	`DSTWR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A result cannot show up in the cycle right after an item was taken.
	`DSTWR_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)

	// A new result only appears when the block was busy in the cycle before.
	`DSTWR_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind ds_twr_distance_fir_smoother dstwr_checker u_dstwr_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the ranging distance smoother.
// Depends on dstwr_pkg and ds_twr_distance_fir_smoother; predicts each filtered
// distance in plain SystemVerilog arithmetic and compares it with the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dstwr_pkg::*;

	localparam int N_RANDOM    = 2000;
	localparam int WATCHDOG    = 20000;
	localparam int DRAIN_WAIT  = 200;

	typedef logic [STAMP_BITS-1:0] stamp_t;

	// One ranging exchange: the six radio timestamps of a full round.
	typedef struct {
		stamp_t poll_tx;
		stamp_t poll_rx;
		stamp_t resp_tx;
		stamp_t resp_rx;
		stamp_t final_tx;
		stamp_t final_rx;
	} exchange_t;

	// One filtered distance as the block presents it.
	typedef struct {
		logic signed [31:0] value_q8;
		logic               zden;
	} distance_t;

	// Directed row: an exchange, an optional scale write before it, and an
	// expected result where it is obvious by inspection.
	typedef struct {
		exchange_t          ex;
		logic               set_scale;
		logic [31:0]        scale;
		logic               known;
		logic signed [31:0] known_dist;
		logic               known_zden;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CM_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	stamp_t poll_tx_time, poll_rx_time, resp_tx_time, resp_rx_time;
	stamp_t final_tx_time, final_rx_time;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] smoothed_distance_q8;
	logic zero_denominator;

	ds_twr_distance_fir_smoother i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.poll_tx_time         (poll_tx_time),
		.poll_rx_time         (poll_rx_time),
		.resp_tx_time         (resp_tx_time),
		.resp_rx_time         (resp_rx_time),
		.final_tx_time        (final_tx_time),
		.final_rx_time        (final_rx_time),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.smoothed_distance_q8 (smoothed_distance_q8),
		.zero_denominator     (zero_denominator)
	);

	// The predictor keeps its own copy of the scale register and delay line.
	logic [31:0]        scale_model;
	logic signed [31:0] history_model [TAPS];
	distance_t          pending_distances [$];

	int  n_errors;
	int  n_items_sent;
	int  n_results_seen;
	int  n_zero_den_seen;
	int  n_saturated_seen;
	int  idle_cycles;
	logic stim_done;
	logic hold_output;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Time of flight in Q8 cm, computed exactly with wide vectors.
	function automatic logic signed [31:0] raw_tof_q8(input exchange_t ex, output logic zden);
		logic [STAMP_BITS-1:0] ra, db, rb, da;
		logic [2*STAMP_BITS-1:0] p1, p2, mag;
		logic [2*STAMP_BITS+31:0] num;
		logic [STAMP_BITS+25:0] den;
		logic [2*STAMP_BITS+31:0] quo;
		logic neg;
		ra = ex.resp_rx - ex.poll_tx;
		db = ex.resp_tx - ex.poll_rx;
		rb = ex.final_rx - ex.resp_tx;
		da = ex.final_tx - ex.resp_rx;
		p1 = ra * rb;
		p2 = da * db;
		neg = p1 < p2;
		mag = neg ? p2 - p1 : p1 - p2;
		num = mag * scale_model;
		den = ({26'd0, ra} + rb + da + db) << 24;
		zden = (den == 0);
		if (zden) begin
			return 0;
		end
		quo = num / den;
		if (neg) begin
			return (quo > 32'h8000_0000) ? 32'sh8000_0000 : -$signed({1'b0, quo[31:0]});
		end
		return (quo > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
	endfunction

	// Shifts a raw distance into the delay line and returns the FIR output.
	function automatic distance_t predict_smoothed(input exchange_t ex);
		distance_t r;
		logic signed [31:0] raw;
		logic signed [63:0] acc;
		logic signed [63:0] y;
		raw = raw_tof_q8(ex, r.zden);
		for (int i = TAPS - 1; i > 0; i--) begin
			history_model[i] = history_model[i - 1];
		end
		history_model[0] = raw;
		acc = 0;
		for (int i = 0; i < TAPS && i < NCOEF; i++) begin
			acc += 64'(history_model[i]) * 64'(COEF_Q16[i]);
		end
		// Arithmetic shift floors, so adding half first rounds ties upward.
		y = (acc + 64'sd32768) >>> 16;
		if (y > 64'sd2147483647) begin
			y = 64'sd2147483647;
		end else if (y < -64'sd2147483648) begin
			y = -64'sd2147483648;
		end
		r.value_q8 = y[31:0];
		return r;
	endfunction

	function automatic stamp_t rand_stamp();
		return {8'($urandom_range(255, 0)), $urandom()};
	endfunction

	// A plausible exchange: random start near anything (wraps included), with
	// realistic reply delays and a time of flight of up to 2000 ticks.
	function automatic exchange_t rand_exchange();
		exchange_t ex;
		int unsigned tof, reply_b, reply_a;
		tof     = $urandom_range(2000, 0);
		reply_b = $urandom_range(1 << 24, 1);
		reply_a = $urandom_range(1 << 24, 1);
		ex.poll_tx  = rand_stamp();
		ex.poll_rx  = rand_stamp();
		ex.resp_tx  = ex.poll_rx + reply_b;
		ex.resp_rx  = ex.poll_tx + 2 * tof + reply_b + $urandom_range(3, 0);
		ex.final_tx = ex.resp_rx + reply_a;
		ex.final_rx = ex.resp_tx + 2 * tof + reply_a + $urandom_range(3, 0);
		return ex;
	endfunction

	function automatic exchange_t noise_exchange();
		exchange_t ex;
		ex.poll_tx  = rand_stamp();
		ex.poll_rx  = rand_stamp();
		ex.resp_tx  = rand_stamp();
		ex.resp_rx  = rand_stamp();
		ex.final_tx = rand_stamp();
		ex.final_rx = rand_stamp();
		return ex;
	endfunction

	function automatic exchange_t uniform_exchange(input stamp_t v);
		exchange_t ex;
		ex.poll_tx  = v;
		ex.poll_rx  = v;
		ex.resp_tx  = v;
		ex.resp_rx  = v;
		ex.final_tx = v;
		ex.final_rx = v;
		return ex;
	endfunction

	// Waits until every expected result has arrived and the block is quiet.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_distances.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_scale(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		scale_model = v;
	endtask

	// Offers one exchange after a random gap and waits for its acceptance.
	// Valid stays high after acceptance until the next gap or the next item.
	task automatic send_exchange(input exchange_t ex);
		int gap;
		gap = $urandom_range(19, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		poll_tx_time  <= ex.poll_tx;
		poll_rx_time  <= ex.poll_rx;
		resp_tx_time  <= ex.resp_tx;
		resp_rx_time  <= ex.resp_rx;
		final_tx_time <= ex.final_tx;
		final_rx_time <= ex.final_rx;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_distances = {pending_distances, predict_smoothed(ex)};
		n_items_sent++;
	endtask

	// Stimulus: reset, a directed table, scale settings, then random rounds.
	initial begin
		row_t rows [$];
		row_t r;
		exchange_t ex;
		logic [31:0] scales [4];
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		poll_tx_time  = '0;
		poll_rx_time  = '0;
		resp_tx_time  = '0;
		resp_rx_time  = '0;
		final_tx_time = '0;
		final_rx_time = '0;
		stim_done     = 1'b0;
		scale_model   = CM_RESET;
		for (int i = 0; i < TAPS; i++) begin
			history_model[i] = 0;
		end
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Equal stamps make all intervals zero: zero result with the flag.
		r = '{ex: uniform_exchange('0), set_scale: 0, scale: 0, known: 1,
			known_dist: 0, known_zden: 1};
		rows = {rows, r};
		r.ex = uniform_exchange('1);
		rows = {rows, r};
		// Intervals summing to exactly 2^40 wrap-free but nonzero.
		r = '{ex: uniform_exchange('0), set_scale: 0, scale: 0, known: 0,
			known_dist: 0, known_zden: 0};
		r.ex.resp_rx = '1;
		rows = {rows, r};
		// Counter wrap between poll and response.
		r.ex = '{poll_tx: '1 - 100, poll_rx: 40'd5, resp_tx: 40'd100005,
			resp_rx: 40'd100500, final_tx: 40'd200500, final_rx: 40'd201000};
		rows = {rows, r};
		// Largest possible magnitude, with full, zero and unit scale.
		r.ex = '{poll_tx: '0, poll_rx: '0, resp_tx: '0, resp_rx: '1,
			final_tx: '1, final_rx: '1};
		r.set_scale = 1; r.scale = '1;
		rows = {rows, r};
		r.ex = '{poll_tx: '0, poll_rx: '0, resp_tx: '1, resp_rx: '0,
			final_tx: '1, final_rx: '1};
		rows = {rows, r};
		r.set_scale = 1; r.scale = '0;
		rows = {rows, r};
		r.set_scale = 1; r.scale = 32'h0000_0001;
		rows = {rows, r};
		r.set_scale = 1; r.scale = CM_RESET;
		for (int i = 0; i < 12; i++) begin
			r.ex = (i % 3 == 0) ? noise_exchange() : rand_exchange();
			rows = {rows, r};
			r.set_scale = 0;
		end
		// Saturation repeatedly to drive the filter to its extremes.
		r.set_scale = 1; r.scale = '1;
		r.ex = '{poll_tx: '0, poll_rx: '0, resp_tx: '0, resp_rx: '1,
			final_tx: '1, final_rx: '1};
		rows = {rows, r};
		r.set_scale = 0;
		for (int i = 0; i < 3; i++) begin
			rows = {rows, r};
		end

		foreach (rows[i]) begin
			if (rows[i].set_scale) begin
				wait_idle();
				write_scale(rows[i].scale);
			end
			send_exchange(rows[i].ex);
			if (rows[i].known) begin
				pending_distances[$].value_q8 = rows[i].known_dist;
				pending_distances[$].zden     = rows[i].known_zden;
			end
		end

		// Random part in phases, each under its own scale setting.
		scales = '{CM_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000};
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			write_scale(ph < 4 ? scales[ph] : $urandom());
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				ex = ($urandom_range(9, 0) < 8) ? rand_exchange() : noise_exchange();
				send_exchange(ex);
			end
		end
		in_valid  <= 1'b0;
		stim_done <= 1'b1;
	end

	// Output stall: each result is stalled for a random, bounded wait, and one
	// result is held off for a long stretch while the next item waits behind it.
	initial begin
		int hold;
		int wait_n;
		out_stall   = 1'b1;
		hold_output = 1'b0;
		@(posedge arst_n);
		forever begin
			out_stall <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_valid);
			if (n_items_sent >= 40 && !hold_output) begin
				hold_output = 1'b1;
				wait_n = 2000;
			end else begin
				wait_n = $urandom_range(19, 0);
			end
			hold = 0;
			while (hold < wait_n) begin
				@(posedge clk);
				hold++;
			end
			out_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!out_valid);
		end
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		distance_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_distances.size() == 0) begin
				$error("unexpected result: distance %0d", smoothed_distance_q8);
				n_errors++;
			end else begin
				want = pending_distances.pop_front();
				if (smoothed_distance_q8 !== want.value_q8) begin
					$error("smoothed_distance_q8: expected %0d, got %0d",
						want.value_q8, smoothed_distance_q8);
					n_errors++;
				end
				if (zero_denominator !== want.zden) begin
					$error("zero_denominator: expected %0b, got %0b",
						want.zden, zero_denominator);
					n_errors++;
				end
				if (want.zden) n_zero_den_seen++;
				if (want.value_q8 == 32'sh7FFF_FFFF || want.value_q8 == 32'sh8000_0000)
					n_saturated_seen++;
			end
			n_results_seen++;
		end
	end

	// Watchdog: counts cycles with no item moving on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		n_errors         = 0;
		n_items_sent     = 0;
		n_results_seen   = 0;
		n_zero_den_seen  = 0;
		n_saturated_seen = 0;
		idle_cycles      = 0;
		fork
			begin
				wait (stim_done === 1'b1);
				while (pending_distances.size() != 0) begin
					@(posedge clk);
				end
				repeat (DRAIN_WAIT) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WATCHDOG);
				$display("timeout with %0d results outstanding", pending_distances.size());
				$display("[ds_twr_distance_fir_smoother] ERROR");
				$finish;
			end
		join_any
		$display("Checked %0d filtered distances from %0d exchanges under several scales;",
			n_results_seen, n_items_sent);
		$display("%0d had a zero interval sum and %0d hit saturation.",
			n_zero_den_seen, n_saturated_seen);
		if (n_errors == 0 && pending_distances.size() == 0) begin
			$display("[ds_twr_distance_fir_smoother] OK");
		end else begin
			$display("[ds_twr_distance_fir_smoother] ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/dstwr_pkg.sv
src/dstwr_ctrl.sv
src/dstwr_dp.sv
src/ds_twr_distance_fir_smoother.sv
src/dstwr_checker.sv
test/testbench.sv
